[hdl/apsu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apsu_pkg: shared definitions of the PowerPC address pair scanner
// Window size, queue size, opcode codes, item kinds and the job record that
// travels from the classifying front to the emitting back.
// ----------------------------------------------------------------------------
package apsu_pkg;

  // Number of words an opened entry stays pending.
  localparam int WINDOW      = 8;
  localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register index width (covers unknown indexes too).
  localparam int CFG_IDX_W   = 2;

  // Primary opcodes, bits 31..26 of the instruction word.
  localparam logic [5:0] OPC_LIS  = 6'd15;
  localparam logic [5:0] OPC_ADDI = 6'd14;
  localparam logic [5:0] OPC_ORI  = 6'd24;
  localparam logic [5:0] OPC_LWZ  = 6'd32;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_OR   = 2'd1,
    KIND_LOAD = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1
  } cfg_idx_e;

  // One closing word together with every entry it closed.
  typedef struct packed {
    logic [31:0]              addr;
    logic [15:0]              low_half;
    kind_e                    kind;
    logic [WINDOW-1:0]        mask;
    logic [WINDOW-1:0][15:0]  upper;
  } job_t;

  // Address formed by an upper half and the closing word's low half.
  function automatic logic [31:0] form_value(kind_e kind, logic [15:0] upper,
                                             logic [15:0] low);
    logic [15:0] hi;
    if (kind == KIND_OR) begin
      hi = upper;
    end else begin
      // Adding the sign-extended low half only touches the upper 16 bits.
      hi = upper + {16{low[15]}};
    end
    return {hi, low};
  endfunction

endpackage
`default_nettype wire

[hdl/apsu_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apsu_if: item channels of the PowerPC address pair scanner
// Valid/ready channels for instruction words in and address results out.
// ----------------------------------------------------------------------------
interface apsu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [31:0] word_address;
  logic        section_start;

  modport source (output valid, output instruction_word, output word_address,
                  output section_start, input ready);
  modport sink (input valid, input instruction_word, input word_address,
                input section_start, output ready);
endinterface

interface apsu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_address;
  logic [31:0] formed_value;
  logic [1:0]  access_kind;
  logic        last_of_run;

  modport source (output valid, output match_address, output formed_value,
                  output access_kind, output last_of_run, input ready);
  modport sink (input valid, input match_address, input formed_value,
                input access_kind, input last_of_run, output ready);
endinterface
`default_nettype wire

[hdl/apsu_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apsu_front: window of pending entries and word classification
// Accepts one word per cycle while the queue has room, keeps the age-ordered window of
// open entries, closes the matching ones and queues a job for each word that closed any.
// ----------------------------------------------------------------------------
module apsu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  apsu_in_if.sink            in_i,
  output apsu_pkg::job_t     push_data_o,
  output logic               push_o,
  input  wire logic          full_i
);
  import apsu_pkg::*;

  logic [WINDOW-1:0]       valid_q, valid_d;
  logic [WINDOW-1:0][4:0]  reg_q, reg_d;
  logic [WINDOW-1:0][15:0] upper_q, upper_d;

  logic              accept;
  logic [5:0]        opc;
  logic [4:0]        rb;
  logic              consumer;
  logic              opener;
  logic [WINDOW-1:0] live;
  logic [WINDOW-1:0] mask;
  logic [WINDOW-1:0] remaining;
  kind_e             kind;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Decode the word.
  assign opc      = in_i.instruction_word[31:26];
  assign rb       = in_i.instruction_word[20:16];
  assign consumer = (opc == OPC_ADDI) || (opc == OPC_ORI) || (opc == OPC_LWZ);
  assign opener   = (opc == OPC_LIS) && (rb == 5'd0);

  always_comb begin
    case (opc)
      OPC_ORI: kind = KIND_OR;
      OPC_LWZ: kind = KIND_LOAD;
      default: kind = KIND_ADD;
    endcase
  end

  // Match every live entry against the base register in parallel.
  always_comb begin
    live = in_i.section_start ? '0 : valid_q;
    for (int k = 0; k < WINDOW; k++) begin
      mask[k] = consumer && live[k] && (reg_q[k] == rb);
    end
    remaining = live & ~mask;
  end

  // Age the window by one word and, for an opening word, open a new entry at the young end.
  always_comb begin
    valid_d = valid_q;
    reg_d   = reg_q;
    upper_d = upper_q;
    if (accept) begin
      for (int k = 1; k < WINDOW; k++) begin
        valid_d[k] = remaining[k-1];
        reg_d[k]   = reg_q[k-1];
        upper_d[k] = upper_q[k-1];
      end
      valid_d[0] = opener;
      reg_d[0]   = in_i.instruction_word[25:21];
      upper_d[0] = in_i.instruction_word[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reg_q   <= reg_d;
    upper_q <= upper_d;
  end

  // A job goes to the queue only when the word closed at least one entry.
  assign push_o               = accept && (|mask);
  assign push_data_o.addr     = in_i.word_address;
  assign push_data_o.low_half = in_i.instruction_word[15:0];
  assign push_data_o.kind     = kind;
  assign push_data_o.mask     = mask;
  assign push_data_o.upper    = upper_q;

endmodule
`default_nettype wire

[hdl/apsu_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apsu_fifo: job queue between front and back
// A short first-in first-out queue of jobs with a registered store.
// ----------------------------------------------------------------------------
module apsu_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire apsu_pkg::job_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output apsu_pkg::job_t       head_o,
  output logic                 empty_o
);
  import apsu_pkg::*;

  job_t              store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = store_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[hdl/apsu_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apsu_back: address forming and result emission
// Takes one job at a time, keeps the closed entries whose address is in
// range and emits them oldest first, one item per cycle while the output is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
module apsu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire apsu_pkg::job_t  head_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  input  wire logic [31:0]     range_low_i,
  input  wire logic [31:0]     range_high_i,
  apsu_out_if.source           out_o
);
  import apsu_pkg::*;

  // Job being worked on.
  logic [WINDOW-1:0]       rem_q, rem_d;
  logic [WINDOW-1:0][15:0] upper_q;
  logic [15:0]             low_q;
  kind_e                   kind_q;
  logic [31:0]             addr_q;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q;
  logic [31:0] out_value_q;
  kind_e       out_kind_q;
  logic        out_last_q;

  logic [WINDOW-1:0] hits;
  logic [SLOT_W-1:0] sel;
  logic [WINDOW-1:0] sel_bit;
  logic              advance;
  logic              emit;
  logic              last;
  logic              load;

  // Range check of every closed entry of the queue head in parallel.
  always_comb begin
    logic [31:0] v;
    for (int k = 0; k < WINDOW; k++) begin
      v       = form_value(head_i.kind, head_i.upper[k], head_i.low_half);
      hits[k] = head_i.mask[k] && (v >= range_low_i) && (v < range_high_i);
    end
  end

  // Pick the oldest remaining entry (highest slot index).
  always_comb begin
    sel     = '0;
    sel_bit = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (rem_q[k]) begin
        sel     = SLOT_W'(k);
        sel_bit = WINDOW'(1) << k;
      end
    end
  end

  assign advance = !out_valid_q || out_o.ready;
  assign emit    = (|rem_q) && advance;
  assign last    = ((rem_q & ~sel_bit) == '0);
  assign load    = !empty_i && ((rem_q == '0) || (emit && last));
  assign pop_o   = load;

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = hits;
    end else if (emit) begin
      rem_d = rem_q & ~sel_bit;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job payload, taken when the next job is loaded.
  always_ff @(posedge clk_i) begin
    if (load) begin
      upper_q <= head_i.upper;
      low_q   <= head_i.low_half;
      kind_q  <= head_i.kind;
      addr_q  <= head_i.addr;
    end
  end

  // Result payload, formed again for the selected entry.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_addr_q  <= addr_q;
      out_value_q <= form_value(kind_q, upper_q[sel], low_q);
      out_kind_q  <= kind_q;
      out_last_q  <= last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.match_address = out_addr_q;
  assign out_o.formed_value  = out_value_q;
  assign out_o.access_kind   = out_kind_q;
  assign out_o.last_of_run   = out_last_q;

endmodule
`default_nettype wire

[hdl/ppc_address_pair_scanner_unit.sv]
// Path: a closing word's job is written into the queue, loaded by the back,
// and its first result is registered in the output register; further results
// of the same word follow one per cycle while the output is not stalled.
// Throughput: one word per cycle while the queue has room; the back emits one
// result for each closed entry in range, and the four-job queue absorbs bursts.
// Reset: all window entries are closed, both range bounds are zero.
`default_nettype none
// ----------------------------------------------------------------------------
// ppc_address_pair_scanner_unit: PowerPC address pair scanner
// Finds load-immediate-shifted / immediate pairs in an instruction stream
// and reports the formed addresses that fall in a configured range.
// ----------------------------------------------------------------------------
module ppc_address_pair_scanner_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  apsu_in_if.sink                             in_i,
  apsu_out_if.source                          out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [apsu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                    cfg_data_i
);
  import apsu_pkg::*;

  logic [31:0] range_low_q;
  logic [31:0] range_high_q;

  job_t push_data;
  logic push;
  logic full;
  job_t head;
  logic pop;
  logic empty;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RANGE_LOW:  range_low_q  <= cfg_data_i;
        CFG_RANGE_HIGH: range_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  apsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_data_o (push_data),
    .push_o      (push),
    .full_i      (full)
  );

  apsu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  apsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .range_low_i  (range_low_q),
    .range_high_i (range_high_q),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

[hdl/apsu_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// apsu_checker: port checks of the PowerPC address pair scanner
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module apsu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_match_address_i,
  input wire logic [31:0] out_formed_value_i,
  input wire logic [1:0]  out_access_kind_i,
  input wire logic        out_last_of_run_i
);
  import apsu_pkg::*;

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_match_address_i) &&
      $stable(out_formed_value_i) && $stable(out_access_kind_i) &&
      $stable(out_last_of_run_i))
    else $error("result payload changed while stalled");

  // Only the three defined access kinds ever leave the block.
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_access_kind_i == KIND_ADD) ||
      (out_access_kind_i == KIND_OR) || (out_access_kind_i == KIND_LOAD))
    else $error("undefined access kind");

  // No result can appear in the cycle right after reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result offered right after reset");

endmodule

bind ppc_address_pair_scanner_unit apsu_checker u_apsu_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_match_address_i (out_o.match_address),
  .out_formed_value_i  (out_o.formed_value),
  .out_access_kind_i   (out_o.access_kind),
  .out_last_of_run_i   (out_o.last_of_run)
);
`default_nettype wire
